// ----- hdl/ppi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg
// Types, constants and arithmetic helpers for the plane pair intersection
// pipeline: item structs, stage structs and split wide multiplications.
// ----------------------------------------------------------------------------
package ppi_pkg;

  // quotient bits of the point division, equal to the point field width
  localparam int unsigned QW = 32;
  // width of the difference of two full 65 by 65 bit products
  localparam int unsigned PW = 131;
  // width of the doubled denominator and of the division remainder
  localparam int unsigned DW = 132;
  // width of the scaled, rounded numerator
  localparam int unsigned NW = 148;
  // numerator scale: sixteen fraction bits plus one for rounding
  localparam int unsigned RND_SHIFT = 17;

  localparam logic [31:0] TOL_RESET = 32'd4295;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [63:0] DIR_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DIR_MIN   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] plane_a_nx;
    logic signed [31:0] plane_a_ny;
    logic signed [31:0] plane_a_nz;
    logic signed [31:0] plane_a_offset;
    logic signed [31:0] plane_b_nx;
    logic signed [31:0] plane_b_ny;
    logic signed [31:0] plane_b_nz;
    logic signed [31:0] plane_b_offset;
  } in_item_t;

  typedef struct packed {
    logic               intersects;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [63:0] dir_x;
    logic signed [63:0] dir_y;
    logic signed [63:0] dir_z;
  } out_item_t;

  // partial products of one 65 by 65 bit signed multiplication
  typedef struct packed {
    logic signed [65:0] hh;
    logic signed [65:0] hl;
    logic signed [65:0] lh;
    logic [63:0]        ll;
  } pp_t;

  // front end result: numerators and denominator of the point
  typedef struct packed {
    logic                 intersects;
    logic [2:0][63:0]     dir;
    logic [2:0][PW-1:0]   num;
    logic [DW-1:0]        den;
  } fr_t;

  // one stage of the point divider, three lanes
  typedef struct packed {
    logic               intersects;
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic [2:0][DW-1:0] rem;
    logic [2:0][QW-1:0] lo;
    logic [2:0][QW-1:0] quo;
    logic [DW-1:0]      dd;
    logic [2:0][63:0]   dir;
  } div_t;

  // split a 65 bit signed multiply into four products of 33 bit parts
  function automatic pp_t pp_mul(input logic signed [64:0] a, input logic signed [64:0] b);
    pp_t                r;
    logic signed [32:0] ah;
    logic signed [32:0] bh;
    logic signed [32:0] al;
    logic signed [32:0] bl;
    ah   = a[64:32];
    bh   = b[64:32];
    al   = {1'b0, a[31:0]};
    bl   = {1'b0, b[31:0]};
    r.hh = ah * bh;
    r.hl = ah * bl;
    r.lh = al * bh;
    r.ll = a[31:0] * b[31:0];
    return r;
  endfunction

  // recombine the partial products
  function automatic logic signed [PW-1:0] pp_sum(input pp_t r);
    logic signed [PW-1:0] s;
    s = (PW'(r.hh) <<< 64) + (PW'(r.hl) <<< 32) + (PW'(r.lh) <<< 32)
        + PW'($signed({1'b0, r.ll}));
    return s;
  endfunction

  // clamp a 65 bit direction component to 64 bits
  function automatic logic [63:0] sat64(input logic signed [64:0] x);
    logic [63:0] r;
    if (x[64] != x[63]) begin
      r = x[64] ? DIR_MIN : DIR_MAX;
    end else begin
      r = x[63:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/plane_plane_intersection.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// plane_plane_intersection
// Line of intersection of two planes: cross product direction, parallel
// test against a tolerance, and the nearest point to the origin.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------
//  config   | cfg_we_i               | cfg_wdata_i (tolerance)
//  input    | in_valid_i / in_ready_o | in_item_i
//  output   | out_valid_o / out_ready_i | out_item_o
//
//  one item per cycle while the skid is empty; before the output register
//  an item passes 7 arithmetic stages and 32 one bit divider stages
//  reset clears all valid bits and loads the tolerance with 4295
//  the whole pipeline holds while a skid register is full; the skid takes
//  the one item that leaves the pipeline while the output is stalled
// ----------------------------------------------------------------------------
module plane_plane_intersection
  import ppi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o
);

  localparam int unsigned NS = 7 + QW;

  logic [31:0]      tol_q;
  logic [NS-1:0]    v_q;
  logic             en;
  fr_t              fr;
  div_t             chain [QW+1];
  out_item_t        res;
  out_item_t        out_q;
  out_item_t        sk_q;
  logic             out_v_q;
  logic             sk_v_q;
  logic             push;
  logic             pop;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // pipeline advances while the skid is empty
  assign en         = !sk_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  ppi_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .in_item_i (in_item_i),
    .tol_i     (tol_q),
    .fr_o      (fr)
  );

  ppi_prep u_prep (
    .clk_i (clk_i),
    .en_i  (en),
    .fr_i  (fr),
    .div_o (chain[0])
  );

  // divider chain
  for (genvar k = 0; k < QW; k++) begin : g_div
    ppi_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (chain[k]),
      .d_o   (chain[k+1])
    );
  end

  // saturate, sign and zero the point when parallel
  always_comb begin
    logic [2:0][31:0] pt;
    logic [31:0]      lim;
    logic [31:0]      mag;
    for (int i = 0; i < 3; i++) begin
      lim = chain[QW].neg[i] ? NEG_LIMIT : POS_LIMIT;
      mag = (chain[QW].ovf[i] || (chain[QW].quo[i] > lim)) ? lim : chain[QW].quo[i];
      pt[i] = chain[QW].neg[i] ? 32'(-mag) : mag;
      if (!chain[QW].intersects) begin
        pt[i] = '0;
      end
    end
    res.intersects = chain[QW].intersects;
    res.point_x    = pt[0];
    res.point_y    = pt[1];
    res.point_z    = pt[2];
    res.dir_x      = chain[QW].dir[0];
    res.dir_y      = chain[QW].dir[1];
    res.dir_z      = chain[QW].dir[2];
  end

  // output register and skid
  assign push = en && v_q[NS-1];
  assign pop  = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (pop) begin
        sk_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        sk_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (pop) begin
        out_q <= sk_q;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        sk_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // skid holds an item only behind a full output register
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid full with empty output register");

  // skid fills only from a stalled output
  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled without an output stall");

  // parallel planes report a zero point
  a_parallel_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.intersects) |->
      (out_item_o.point_x == 0 && out_item_o.point_y == 0 && out_item_o.point_z == 0))
    else $error("non-zero point for parallel planes");

endmodule
`default_nettype wire

// ----- hdl/ppi_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_front
// Five stage front end: normal products, cross product and offset terms,
// split wide products, their sums, then numerators and the denominator.
// ----------------------------------------------------------------------------
module ppi_front
  import ppi_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     en_i,
  input  wire in_item_t in_item_i,
  input  wire logic [31:0] tol_i,
  output fr_t           fr_o
);

  logic signed [63:0]   m_q [12];
  logic signed [64:0]   dir_q [3];
  logic signed [64:0]   u_q [3];
  pp_t                  pp_q [9];
  logic                 int3_q;
  logic [63:0]          dsat3_q [3];
  logic signed [PW-1:0] p_q [9];
  logic                 int4_q;
  logic [63:0]          dsat4_q [3];
  fr_t                  fr_q;
  fr_t                  fr_d;
  logic                 far_d;

  // stage one: 32 by 32 products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= in_item_i.plane_a_ny * in_item_i.plane_b_nz;
      m_q[1]  <= in_item_i.plane_a_nz * in_item_i.plane_b_ny;
      m_q[2]  <= in_item_i.plane_a_nz * in_item_i.plane_b_nx;
      m_q[3]  <= in_item_i.plane_a_nx * in_item_i.plane_b_nz;
      m_q[4]  <= in_item_i.plane_a_nx * in_item_i.plane_b_ny;
      m_q[5]  <= in_item_i.plane_a_ny * in_item_i.plane_b_nx;
      m_q[6]  <= in_item_i.plane_b_offset * in_item_i.plane_a_nx;
      m_q[7]  <= in_item_i.plane_a_offset * in_item_i.plane_b_nx;
      m_q[8]  <= in_item_i.plane_b_offset * in_item_i.plane_a_ny;
      m_q[9]  <= in_item_i.plane_a_offset * in_item_i.plane_b_ny;
      m_q[10] <= in_item_i.plane_b_offset * in_item_i.plane_a_nz;
      m_q[11] <= in_item_i.plane_a_offset * in_item_i.plane_b_nz;
    end
  end

  // stage two: direction and offset combination
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= 65'(m_q[2*i]) - 65'(m_q[2*i+1]);
        u_q[i]   <= 65'(m_q[6+2*i]) - 65'(m_q[7+2*i]);
      end
    end
  end

  // parallel test on the exact direction
  always_comb begin
    logic [64:0] mag;
    far_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag = dir_q[i][64] ? 65'(-dir_q[i]) : 65'(dir_q[i]);
      if (mag > 65'(tol_i)) begin
        far_d = 1'b1;
      end
    end
  end

  // stage three: partial products of u x dir and of |dir|^2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q[0] <= pp_mul(u_q[1], dir_q[2]);
      pp_q[1] <= pp_mul(u_q[2], dir_q[1]);
      pp_q[2] <= pp_mul(u_q[2], dir_q[0]);
      pp_q[3] <= pp_mul(u_q[0], dir_q[2]);
      pp_q[4] <= pp_mul(u_q[0], dir_q[1]);
      pp_q[5] <= pp_mul(u_q[1], dir_q[0]);
      for (int i = 0; i < 3; i++) begin
        pp_q[6+i]  <= pp_mul(dir_q[i], dir_q[i]);
        dsat3_q[i] <= sat64(dir_q[i]);
      end
      int3_q <= far_d;
    end
  end

  // stage four: full products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        p_q[i] <= pp_sum(pp_q[i]);
      end
      for (int i = 0; i < 3; i++) begin
        dsat4_q[i] <= dsat3_q[i];
      end
      int4_q <= int3_q;
    end
  end

  // stage five: numerators and denominator
  always_comb begin
    fr_d.intersects = int4_q;
    for (int i = 0; i < 3; i++) begin
      fr_d.dir[i] = dsat4_q[i];
      fr_d.num[i] = p_q[2*i] - p_q[2*i+1];
    end
    fr_d.den = DW'($unsigned(p_q[6])) + DW'($unsigned(p_q[7])) + DW'($unsigned(p_q[8]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr_q <= fr_d;
    end
  end

  assign fr_o = fr_q;

endmodule
`default_nettype wire

// ----- hdl/ppi_prep.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_prep
// Two stages ahead of the divider: sign and magnitude of each numerator,
// rounding offset, doubled denominator, overflow test and first remainder.
// ----------------------------------------------------------------------------
module ppi_prep
  import ppi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire fr_t  fr_i,
  output div_t      div_o
);

  logic               int6_q;
  logic [2:0]         neg6_q;
  logic [2:0][NW-1:0] nn6_q;
  logic [DW-1:0]      dd6_q;
  logic [2:0][63:0]   dir6_q;
  logic [2:0]         neg6_d;
  logic [2:0][NW-1:0] nn6_d;
  div_t               div_q;
  div_t               div_d;

  // magnitude, scaled and offset by the denominator for rounding
  always_comb begin
    logic [PW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      neg6_d[i] = fr_i.num[i][PW-1];
      mag       = neg6_d[i] ? PW'(-$signed(fr_i.num[i])) : fr_i.num[i];
      nn6_d[i]  = (NW'(mag) << RND_SHIFT) + NW'(fr_i.den);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      int6_q <= fr_i.intersects;
      neg6_q <= neg6_d;
      nn6_q  <= nn6_d;
      dd6_q  <= {fr_i.den[DW-2:0], 1'b0};
      dir6_q <= fr_i.dir;
    end
  end

  // quotient overflow and starting remainder
  always_comb begin
    div_d.intersects = int6_q;
    div_d.neg        = neg6_q;
    div_d.dd         = dd6_q;
    div_d.dir        = dir6_q;
    for (int i = 0; i < 3; i++) begin
      div_d.rem[i] = DW'(nn6_q[i][NW-1:QW]);
      div_d.ovf[i] = DW'(nn6_q[i][NW-1:QW]) >= dd6_q;
      div_d.lo[i]  = nn6_q[i][QW-1:0];
      div_d.quo[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule
`default_nettype wire

// ----- hdl/ppi_div_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_div_step
// One registered restoring division step for three lanes: one quotient
// bit per lane, shared divisor.
// ----------------------------------------------------------------------------
module ppi_div_step
  import ppi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire div_t d_i,
  output div_t      d_o
);

  div_t d_q;
  div_t d_d;

  // trial subtract per lane
  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    d_d = d_i;
    for (int i = 0; i < 3; i++) begin
      trial      = {d_i.rem[i], d_i.lo[i][QW-1]};
      ge         = trial >= {1'b0, d_i.dd};
      trial      = ge ? trial - {1'b0, d_i.dd} : trial;
      d_d.rem[i] = trial[DW-1:0];
      d_d.quo[i] = {d_i.quo[i][QW-2:0], ge};
      d_d.lo[i]  = {d_i.lo[i][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule
`default_nettype wire

// ----- tb/tb_plane_plane_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plane_plane_intersection
// Self-checking bench for the plane pair intersection block. Directed and
// random plane pairs are pushed through the valid/ready input, the expected
// direction, intersect flag and nearest point are worked out in wide integer
// arithmetic and compared in order with every item leaving the block.
// ----------------------------------------------------------------------------
module tb_plane_plane_intersection
  import ppi_pkg::*;
;

  typedef logic signed [199:0] wide_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;

  int unsigned errors;
  int unsigned cycles;
  int unsigned n_sent;
  int unsigned n_parallel;
  int unsigned n_meet;
  logic [31:0] tolerance;
  bit          long_hold;
  bit          rx_gaps;

  plane_plane_intersection dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // intersection predictor for one plane pair
  function automatic out_item_t intersect_planes(input in_item_t p, input logic [31:0] tol);
    out_item_t r;
    wide_t     a[3], b[3], dv[3], u[3], num[3], den, da, db, mag, q;
    logic      par;
    a[0] = wide_t'(p.plane_a_nx); a[1] = wide_t'(p.plane_a_ny);
    a[2] = wide_t'(p.plane_a_nz);
    b[0] = wide_t'(p.plane_b_nx); b[1] = wide_t'(p.plane_b_ny);
    b[2] = wide_t'(p.plane_b_nz);
    da   = wide_t'(p.plane_a_offset);
    db   = wide_t'(p.plane_b_offset);
    dv[0] = a[1] * b[2] - a[2] * b[1];
    dv[1] = a[2] * b[0] - a[0] * b[2];
    dv[2] = a[0] * b[1] - a[1] * b[0];
    par = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag = (dv[i] < 0) ? -dv[i] : dv[i];
      if (mag > wide_t'({1'b0, tol})) par = 1'b0;
    end
    r = '0;
    // direction clamps to the signed 64 bit range
    r.dir_x = (dv[0] > wide_t'(DIR_MAX)) ? DIR_MAX :
              (dv[0] < -wide_t'(DIR_MAX) - 1) ? DIR_MIN : dv[0][63:0];
    r.dir_y = (dv[1] > wide_t'(DIR_MAX)) ? DIR_MAX :
              (dv[1] < -wide_t'(DIR_MAX) - 1) ? DIR_MIN : dv[1][63:0];
    r.dir_z = (dv[2] > wide_t'(DIR_MAX)) ? DIR_MAX :
              (dv[2] < -wide_t'(DIR_MAX) - 1) ? DIR_MIN : dv[2][63:0];
    r.intersects = !par;
    if (par) return r;
    for (int i = 0; i < 3; i++) u[i] = db * a[i] - da * b[i];
    num[0] = u[1] * dv[2] - u[2] * dv[1];
    num[1] = u[2] * dv[0] - u[0] * dv[2];
    num[2] = u[0] * dv[1] - u[1] * dv[0];
    den = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
    for (int i = 0; i < 3; i++) begin
      // rounded to nearest, ties away from zero, then clamped
      mag = (num[i] < 0) ? -num[i] : num[i];
      q = ((mag <<< 17) + den) / (den <<< 1);
      if (num[i] < 0) q = (q > 64'sh8000_0000) ? -wide_t'(64'sh8000_0000) : -q;
      else if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
      case (i)
        0: r.point_x = q[31:0];
        1: r.point_y = q[31:0];
        default: r.point_z = q[31:0];
      endcase
    end
    return r;
  endfunction

  class result_board;
    out_item_t pending[$];

    function void note_input(in_item_t p, logic [31:0] tol);
      pending.push_back(intersect_planes(p, tol));
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result item, dir_x", got.dir_x, '0);
        return;
      end
      want = pending.pop_front();
      if (want.intersects) n_meet++;
      else n_parallel++;
      if (got.intersects !== want.intersects)
        report_mismatch("intersects", 64'(got.intersects), 64'(want.intersects));
      if (got.point_x !== want.point_x)
        report_mismatch("point_x", 64'(got.point_x), 64'(want.point_x));
      if (got.point_y !== want.point_y)
        report_mismatch("point_y", 64'(got.point_y), 64'(want.point_y));
      if (got.point_z !== want.point_z)
        report_mismatch("point_z", 64'(got.point_z), 64'(want.point_z));
      if (got.dir_x !== want.dir_x) report_mismatch("dir_x", got.dir_x, want.dir_x);
      if (got.dir_y !== want.dir_y) report_mismatch("dir_y", got.dir_y, want.dir_y);
      if (got.dir_z !== want.dir_z) report_mismatch("dir_z", got.dir_z, want.dir_z);
    endtask
  endclass

  result_board board;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 200000) begin
      $display("timeout");
      $display("tb_plane_plane_intersection: FAIL");
      $finish;
    end
  end

  // output side: check each accepted item
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_item_o);
  end

  // receiver stall pattern
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        for (int i = 0; i < 150; i++) @(negedge clk_i);
        long_hold = 0;
      end
      gap = rx_gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one item and wait for it to be taken
  task automatic send_planes(input in_item_t p, input bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_input(p, tolerance);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_tolerance(input logic [31:0] v);
    drain();
    repeat (50) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tolerance = v;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      3: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      4: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t rand_pair();
    in_item_t p;
    int unsigned k;
    p.plane_a_nx = rand_coef(); p.plane_a_ny = rand_coef();
    p.plane_a_nz = rand_coef(); p.plane_a_offset = rand_coef();
    p.plane_b_nx = rand_coef(); p.plane_b_ny = rand_coef();
    p.plane_b_nz = rand_coef(); p.plane_b_offset = rand_coef();
    // some pairs with parallel or nearly parallel normals
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, 3);
      p.plane_b_nx = p.plane_a_nx * k;
      p.plane_b_ny = p.plane_a_ny * k;
      p.plane_b_nz = p.plane_a_nz * k + $urandom_range(0, 2);
    end
    return p;
  endfunction

  function automatic in_item_t make_pair(input logic [31:0] ax, ay, az, ad,
                                          bx, by, bz, bd);
    in_item_t p;
    p.plane_a_nx = ax; p.plane_a_ny = ay; p.plane_a_nz = az; p.plane_a_offset = ad;
    p.plane_b_nx = bx; p.plane_b_ny = by; p.plane_b_nz = bz; p.plane_b_offset = bd;
    return p;
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hFFFF_0000;

  initial begin
    board = new();
    errors = 0; cycles = 0; n_sent = 0; n_parallel = 0; n_meet = 0;
    tolerance = TOL_RESET;
    long_hold = 0; rx_gaps = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; in_item_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: axes, parallel pairs, extremes, rounding ties, saturation
    send_planes(make_pair(ONE, 0, 0, MONE, 0, ONE, 0, ONE), 0);
    send_planes(make_pair(0, 0, ONE, ONE, 0, 0, MONE, ONE), 0);
    send_planes(make_pair(ONE, ONE, 0, 0, ONE, ONE, 0, ONE), 0);
    send_planes(make_pair(0, 0, 0, ONE, ONE, 0, 0, ONE), 0);
    send_planes(make_pair(1, 0, 0, 5, 0, 1, 0, 3), 0);
    send_planes(make_pair(3, 0, 0, 1, 0, 2, 0, 1), 0);
    send_planes(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0);
    send_planes(make_pair(32'h8000_0000, 32'h8000_0000, 0, 0,
                          32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 0);
    send_planes(make_pair(0, 32'h8000_0000, 0, 0, 0, 0, 32'h8000_0000, 0), 0);
    send_planes(make_pair(0, 1, 0, 32'h7FFF_FFFF, 0, 0, 1, 32'h8000_0000), 0);
    send_planes(make_pair(0, 1, 0, 32'h8000_0000, 0, 0, 1, 32'h7FFF_FFFF), 0);
    send_planes(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          ONE, MONE, ONE, MONE), 0);
    send_planes(make_pair(ONE, 0, 0, 32'h8000_0000, 0, MONE, 0, 32'h7FFF_FFFF), 0);
    send_planes(make_pair(65, 0, 0, 0, 65, 1, 0, 0), 0);

    // tolerance extremes on small cross products
    set_tolerance(32'd0);
    send_planes(make_pair(1, 0, 0, 7, 0, 1, 0, 9), 0);
    send_planes(make_pair(2, 2, 2, ONE, 1, 1, 1, 0), 0);
    set_tolerance(32'hFFFF_FFFF);
    send_planes(make_pair(ONE, 0, 0, 0, 0, ONE, 0, 0), 0);
    send_planes(make_pair(2, 0, 0, ONE, 0, 32'h7FFF_FFFF, 0, ONE), 0);
    send_planes(make_pair(ONE, 0, 0, ONE, 0, ONE, 0, ONE), 0);

    // random phases under several tolerances
    rx_gaps = 1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_tolerance(TOL_RESET);
        1: set_tolerance(32'd0);
        2: set_tolerance($urandom());
        default: set_tolerance(32'hFFFF_FFFF);
      endcase
      if (ph == 1) begin
        // receiver stops for a long stretch while items keep coming
        long_hold = 1;
        for (int i = 0; i < 80; i++) send_planes(rand_pair(), 0);
      end
      for (int i = 0; i < 113; i++) begin
        send_planes(rand_pair(), $urandom_range(0, 3) != 0);
        if (i == 60) drain();
      end
    end
    rx_gaps = 0;
    drain();
    repeat (60) @(negedge clk_i);

    $display("covered %0d plane pairs (%0d meeting, %0d parallel) under several tolerances,",
             n_sent, n_meet, n_parallel);
    $display("with axis, parallel, extreme and saturating cases plus stalls");
    if (errors == 0 && board.pending.size() == 0) begin
      $display("tb_plane_plane_intersection: PASS");
    end else begin
      $display("tb_plane_plane_intersection: FAIL");
    end
    $finish;
  end

endmodule
